// File: rtl/zero_run_decompressor_top_macros.svh
// assertion macros shared by the zero-run decompressor rtl
`ifndef ZERO_RUN_DECOMPRESSOR_TOP_MACROS_SVH
`define ZERO_RUN_DECOMPRESSOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// concurrent property checked at every edge out of reset
`define ZRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition in this cycle implies a result in the next cycle
`define ZRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ZRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ZRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/zrd_pkg.sv
// shared types, codes and helpers of the zero-run decompressor
`default_nettype none

package zrd_pkg;

    // default longest varint in bytes
    localparam int MAX_VARINT_BYTES = 7;

    // most result items one input item can cause
    localparam int MAX_RESULTS = 3;

    // nibble value that calls for a varint extension
    localparam logic [3:0] NIBBLE_EXT = 4'd15;

    // decoder phases
    localparam logic [2:0] PH_TOKEN    = 3'd0;
    localparam logic [2:0] PH_LIT_EXT  = 3'd1;
    localparam logic [2:0] PH_LITERALS = 3'd2;
    localparam logic [2:0] PH_ZERO_EXT = 3'd3;
    localparam logic [2:0] PH_DRAIN    = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_RUN     = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_SPACE = 2'd1;
    localparam logic [1:0] ERR_CORRUPT  = 2'd2;

    // configuration register indexes
    localparam logic REG_INPUT_LENGTH    = 1'b0;
    localparam logic REG_OUTPUT_CAPACITY = 1'b1;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] run_length;
        logic [31:0] total_length;
        logic [1:0]  error_code;
        logic        last;
    } t_result;

    // output room left, clamped at zero
    function automatic logic [31:0] room_left(input logic [31:0] cap,
                                              input logic [31:0] prod);
        return (cap > prod) ? (cap - prod) : 32'd0;
    endfunction

    // build a result item
    function automatic t_result make_result(input logic [1:0]  kind,
                                            input logic [7:0]  data_byte,
                                            input logic [31:0] run_length,
                                            input logic [31:0] total_length,
                                            input logic [1:0]  error_code,
                                            input logic        last);
        t_result r;
        r.kind         = kind;
        r.data_byte    = data_byte;
        r.run_length   = run_length;
        r.total_length = total_length;
        r.error_code   = error_code;
        r.last         = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/zero_run_decompressor_top.sv
// top level of the zero-run decompressor
//
//  channel   direction  handshake                     payload
//  in        sink       i_in_valid / o_in_ready       i_in_byte
//  out       source     o_out_valid / i_out_ready     o_kind, o_data_byte, o_run_length,
//                                                     o_total_length, o_error_code, o_last
//  cfg       sink       i_cfg_we (no wait)            i_cfg_idx, i_cfg_data
//
//  one compressed byte per cycle while the bank is free; a byte with more than one result
//  item holds the three-slot bank and the next byte waits until only its last item is left
//  a byte passes the input register, then the result bank, before its first item is sent
//  the whole frame step is one pass of logic between the input register and the bank
//  synchronous active-low reset clears the decoder state and both config registers
//  the input side stalls while a byte waits in the input register and the bank holds two
//  or more unsent items, or one unsent item that the receiver does not take in this cycle
`default_nettype none

`include "zero_run_decompressor_top_macros.svh"

module zero_run_decompressor_top #(
    parameter int MAX_VARINT_BYTES = zrd_pkg::MAX_VARINT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [31:0] o_run_length,
    output logic [31:0] o_total_length,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    localparam int VW = 7 * MAX_VARINT_BYTES;
    localparam int SW = (MAX_VARINT_BYTES > 1) ? $clog2(MAX_VARINT_BYTES) : 1;

    logic [31:0]      r_input_length;
    logic [31:0]      r_output_capacity;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [2:0]       r_phase;
    logic [3:0]       r_zero_nibble;
    logic [VW-1:0]    r_varint;
    logic [SW-1:0]    r_shift_step;
    logic [31:0]      r_lits_left;
    logic [31:0]      r_consumed;
    logic [31:0]      r_produced;
    logic [2:0]       n_phase;
    logic [3:0]       n_zero_nibble;
    logic [VW-1:0]    n_varint;
    logic [SW-1:0]    n_shift_step;
    logic [31:0]      n_lits_left;
    logic [31:0]      n_consumed;
    logic [31:0]      n_produced;
    zrd_pkg::t_result step_res [zrd_pkg::MAX_RESULTS];
    logic [1:0]       step_count;
    zrd_pkg::t_result out_res;
    logic             bank_free;
    logic             fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_length    <= 32'd0;
            r_output_capacity <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                zrd_pkg::REG_INPUT_LENGTH:    r_input_length    <= i_cfg_data;
                zrd_pkg::REG_OUTPUT_CAPACITY: r_output_capacity <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register handshake
    assign fire       = r_in_valid && bank_free;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    // frame step logic
    zrd_step #(
        .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
    ) u_step (
        .i_byte            (r_in_byte),
        .i_input_length    (r_input_length),
        .i_output_capacity (r_output_capacity),
        .i_phase           (r_phase),
        .i_zero_nibble     (r_zero_nibble),
        .i_varint          (r_varint),
        .i_shift_step      (r_shift_step),
        .i_lits_left       (r_lits_left),
        .i_consumed        (r_consumed),
        .i_produced        (r_produced),
        .o_phase           (n_phase),
        .o_zero_nibble     (n_zero_nibble),
        .o_varint          (n_varint),
        .o_shift_step      (n_shift_step),
        .o_lits_left       (n_lits_left),
        .o_consumed        (n_consumed),
        .o_produced        (n_produced),
        .o_res             (step_res),
        .o_count           (step_count)
    );

    // decoder state advances once per stepped byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= zrd_pkg::PH_TOKEN;
            r_zero_nibble <= 4'd0;
            r_varint      <= '0;
            r_shift_step  <= '0;
            r_lits_left   <= 32'd0;
            r_consumed    <= 32'd0;
            r_produced    <= 32'd0;
        end else if (fire) begin
            r_phase       <= n_phase;
            r_zero_nibble <= n_zero_nibble;
            r_varint      <= n_varint;
            r_shift_step  <= n_shift_step;
            r_lits_left   <= n_lits_left;
            r_consumed    <= n_consumed;
            r_produced    <= n_produced;
        end
    end

    // result bank
    zrd_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire),
        .i_count     (step_count),
        .i_res       (step_res),
        .i_out_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_res       (out_res),
        .o_free      (bank_free)
    );

    assign o_kind         = out_res.kind;
    assign o_data_byte    = out_res.data_byte;
    assign o_run_length   = out_res.run_length;
    assign o_total_length = out_res.total_length;
    assign o_error_code   = out_res.error_code;
    assign o_last         = out_res.last;

    `ZRD_ASSERT(a_drain_mid_job, i_clk, i_rst_n,
        (r_phase == zrd_pkg::PH_DRAIN) |-> (r_consumed != 32'd0), "drain outside a job")
    `ZRD_ASSERT(a_lits_pending, i_clk, i_rst_n,
        (r_phase == zrd_pkg::PH_LITERALS) |-> (r_lits_left != 32'd0),
        "literal phase with no literals left")

endmodule

`default_nettype wire

// File: rtl/zrd_step.sv
// single-pass next-state and result logic for one compressed byte
`default_nettype none

module zrd_step #(
    parameter int MAX_VARINT_BYTES = zrd_pkg::MAX_VARINT_BYTES,
    localparam int VW = 7 * MAX_VARINT_BYTES,
    localparam int SW = (MAX_VARINT_BYTES > 1) ? $clog2(MAX_VARINT_BYTES) : 1,
    localparam int CW = (VW + 1 > 33) ? VW + 1 : 33
) (
    input  logic [7:0]       i_byte,
    input  logic [31:0]      i_input_length,
    input  logic [31:0]      i_output_capacity,
    input  logic [2:0]       i_phase,
    input  logic [3:0]       i_zero_nibble,
    input  logic [VW-1:0]    i_varint,
    input  logic [SW-1:0]    i_shift_step,
    input  logic [31:0]      i_lits_left,
    input  logic [31:0]      i_consumed,
    input  logic [31:0]      i_produced,
    output logic [2:0]       o_phase,
    output logic [3:0]       o_zero_nibble,
    output logic [VW-1:0]    o_varint,
    output logic [SW-1:0]    o_shift_step,
    output logic [31:0]      o_lits_left,
    output logic [31:0]      o_consumed,
    output logic [31:0]      o_produced,
    output zrd_pkg::t_result o_res [zrd_pkg::MAX_RESULTS],
    output logic [1:0]       o_count
);

    logic [2:0]       ph;
    logic [3:0]       zn;
    logic [VW-1:0]    vv;
    logic [SW-1:0]    vs;
    logic [31:0]      ll;
    logic [31:0]      prod;
    logic [1:0]       cnt;
    logic [1:0]       err;
    logic [32:0]      after;
    logic             is_last;
    logic [31:0]      job_rem;
    logic [VW-1:0]    vfeed;
    logic             v_over;
    logic             do_start;
    logic             do_after;
    logic             do_zrun;
    logic [CW-1:0]    l_val;
    logic [CW-1:0]    z_val;
    zrd_pkg::t_result res [zrd_pkg::MAX_RESULTS];

    // varint byte merged into the accumulated value
    always_comb begin
        vfeed = i_varint;
        for (int g = 0; g < MAX_VARINT_BYTES; g++) begin
            if (i_shift_step == SW'(g)) begin
                vfeed[7*g +: 7] = vfeed[7*g +: 7] | i_byte[6:0];
            end
        end
        v_over = i_byte[7] && (i_shift_step == SW'(MAX_VARINT_BYTES - 1));
    end

    // job position of this byte
    assign after   = {1'b0, i_consumed} + 33'd1;
    assign is_last = after >= {1'b0, i_input_length};
    assign job_rem = is_last ? 32'd0 : (i_input_length - after[31:0]);

    // frame decode for one byte
    always_comb begin
        ph       = i_phase;
        zn       = i_zero_nibble;
        vv       = i_varint;
        vs       = i_shift_step;
        ll       = i_lits_left;
        prod     = i_produced;
        cnt      = 2'd0;
        err      = zrd_pkg::ERR_NONE;
        do_start = 1'b0;
        do_after = 1'b0;
        do_zrun  = 1'b0;
        l_val    = '0;
        z_val    = '0;
        for (int k = 0; k < zrd_pkg::MAX_RESULTS; k++) begin
            res[k] = '0;
        end

        // main byte handling
        case (i_phase)
            zrd_pkg::PH_TOKEN: begin
                if (i_byte == 8'd0) begin
                    err = zrd_pkg::ERR_CORRUPT;
                end else begin
                    zn = i_byte[3:0];
                    if (i_byte[7:4] == zrd_pkg::NIBBLE_EXT) begin
                        vv = '0;
                        vs = '0;
                        ph = zrd_pkg::PH_LIT_EXT;
                    end else begin
                        do_start = 1'b1;
                        l_val    = CW'(i_byte[7:4]);
                    end
                end
            end
            zrd_pkg::PH_LIT_EXT: begin
                vv = vfeed;
                if (v_over) begin
                    err = zrd_pkg::ERR_CORRUPT;
                end else if (i_byte[7]) begin
                    vs = vs + SW'(1);
                end else begin
                    do_start = 1'b1;
                    l_val    = CW'(vfeed) + CW'(zrd_pkg::NIBBLE_EXT);
                end
            end
            zrd_pkg::PH_LITERALS: begin
                res[cnt] = zrd_pkg::make_result(zrd_pkg::KIND_LITERAL, i_byte, 32'd0,
                                                32'd0, zrd_pkg::ERR_NONE, 1'b0);
                cnt  = cnt + 2'd1;
                prod = prod + 32'd1;
                ll   = ll - 32'd1;
                if (ll == 32'd0) begin
                    do_after = 1'b1;
                end
            end
            zrd_pkg::PH_ZERO_EXT: begin
                vv = vfeed;
                if (v_over) begin
                    err = zrd_pkg::ERR_CORRUPT;
                end else if (i_byte[7]) begin
                    vs = vs + SW'(1);
                end else begin
                    do_zrun = 1'b1;
                    z_val   = CW'(vfeed) + CW'(zrd_pkg::NIBBLE_EXT);
                end
            end
            default: begin
                ph = zrd_pkg::PH_DRAIN;
            end
        endcase

        // literal count checks
        if (do_start) begin
            if (l_val > CW'(job_rem)) begin
                err = zrd_pkg::ERR_CORRUPT;
            end else if (l_val > CW'(zrd_pkg::room_left(i_output_capacity, prod))) begin
                err = zrd_pkg::ERR_NO_SPACE;
            end else if (l_val == '0) begin
                do_after = 1'b1;
            end else begin
                ll = l_val[31:0];
                ph = zrd_pkg::PH_LITERALS;
            end
        end

        // zero-run nibble once literals are through
        if (do_after) begin
            if (zn == zrd_pkg::NIBBLE_EXT) begin
                vv = '0;
                vs = '0;
                ph = zrd_pkg::PH_ZERO_EXT;
            end else begin
                do_zrun = 1'b1;
                z_val   = CW'(zn);
            end
        end

        // emit the zero run if it fits
        if (do_zrun) begin
            if (z_val > CW'(zrd_pkg::room_left(i_output_capacity, prod))) begin
                err = zrd_pkg::ERR_NO_SPACE;
            end else begin
                if (z_val != '0) begin
                    res[cnt] = zrd_pkg::make_result(zrd_pkg::KIND_RUN, 8'd0, z_val[31:0],
                                                    32'd0, zrd_pkg::ERR_NONE, 1'b0);
                    cnt  = cnt + 2'd1;
                    prod = prod + z_val[31:0];
                end
                ph = zrd_pkg::PH_TOKEN;
            end
        end

        // error item ends the frame
        if (err != zrd_pkg::ERR_NONE) begin
            res[cnt] = zrd_pkg::make_result(zrd_pkg::KIND_ERROR, 8'd0, 32'd0, 32'd0,
                                            err, 1'b1);
            cnt = cnt + 2'd1;
            ph  = zrd_pkg::PH_DRAIN;
        end

        // job end: done report or truncated frame
        if (is_last) begin
            if (ph == zrd_pkg::PH_TOKEN) begin
                res[cnt] = zrd_pkg::make_result(zrd_pkg::KIND_DONE, 8'd0, 32'd0, prod,
                                                zrd_pkg::ERR_NONE, 1'b1);
                cnt = cnt + 2'd1;
            end else if (ph != zrd_pkg::PH_DRAIN) begin
                res[cnt] = zrd_pkg::make_result(zrd_pkg::KIND_ERROR, 8'd0, 32'd0, 32'd0,
                                                zrd_pkg::ERR_CORRUPT, 1'b1);
                cnt = cnt + 2'd1;
            end
            ph   = zrd_pkg::PH_TOKEN;
            zn   = 4'd0;
            vv   = '0;
            vs   = '0;
            ll   = 32'd0;
            prod = 32'd0;
        end
    end

    assign o_phase       = ph;
    assign o_zero_nibble = zn;
    assign o_varint      = vv;
    assign o_shift_step  = vs;
    assign o_lits_left   = ll;
    assign o_consumed    = is_last ? 32'd0 : after[31:0];
    assign o_produced    = prod;
    assign o_res         = res;
    assign o_count       = cnt;

endmodule

`default_nettype wire

// File: rtl/zrd_outbuf.sv
// result bank that holds the items of one input byte and sends them in order
`default_nettype none

`include "zero_run_decompressor_top_macros.svh"

module zrd_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [1:0]       i_count,
    input  zrd_pkg::t_result i_res [zrd_pkg::MAX_RESULTS],
    input  logic             i_out_ready,
    output logic             o_valid,
    output zrd_pkg::t_result o_res,
    output logic             o_free
);

    logic [1:0]       r_left;
    logic [1:0]       n_left;
    zrd_pkg::t_result r_res [zrd_pkg::MAX_RESULTS];
    logic             pop;

    assign o_valid = r_left != 2'd0;
    assign o_res   = r_res[0];
    assign pop     = o_valid && i_out_ready;
    // bank can take new items when empty or once its last one leaves this cycle
    assign o_free  = (r_left == 2'd0) || ((r_left == 2'd1) && i_out_ready);

    // held item count
    always_comb begin
        if (i_load) begin
            n_left = i_count;
        end else if (pop) begin
            n_left = r_left - 2'd1;
        end else begin
            n_left = r_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
        end else begin
            r_left <= n_left;
        end
    end

    // item slots: load all, shift toward the head on each send
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end else if (pop) begin
            for (int k = 0; k < zrd_pkg::MAX_RESULTS - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

    `ZRD_ASSERT(a_load_free, i_clk, i_rst_n, i_load |-> o_free, "result bank overwritten")
    `ZRD_ASSERT_NEXT(a_pop_count, i_clk, i_rst_n, pop && !i_load, r_left == $past(r_left) - 2'd1, "item count off after send")
    `ZRD_ASSERT(a_last_on_end, i_clk, i_rst_n, (o_valid && (o_res.kind == zrd_pkg::KIND_DONE || o_res.kind == zrd_pkg::KIND_ERROR)) |-> o_res.last, "final item without last")

endmodule

`default_nettype wire
